// File: hdl/sffd_pkg.sv
package sffd_pkg;

   localparam int MAX_FRAME_DEF    = 64;
   localparam int HEADER_BYTES_DEF = 3;
   localparam int FRONT_DEPTH_DEF  = 4;

   localparam int BYTE_W    = 8;
   localparam int POS_W     = 6;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int TOTAL_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_ID = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANALOG_ID  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THERM_ID   = 2'd3;

   localparam logic [KIND_W-1:0] KIND_BATTERY    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ANALOG     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_THERMISTOR = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_FRAME      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SUM    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN_ID = 2'd2;

   localparam logic [BYTE_W-1:0] SYNC_RESET       = 8'd0;
   localparam logic [BYTE_W-1:0] BATTERY_ID_RESET = 8'd1;
   localparam logic [BYTE_W-1:0] ANALOG_ID_RESET  = 8'd2;
   localparam logic [BYTE_W-1:0] THERM_ID_RESET   = 8'd3;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SCAN,
      PH_HDR0,
      PH_HDR2,
      PH_SUM,
      PH_CHECK,
      PH_STATUS,
      PH_EMIT_RD,
      PH_EMIT_WR
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_byte;
      logic [BYTE_W-1:0] battery_id;
      logic [BYTE_W-1:0] analog_id;
      logic [BYTE_W-1:0] thermistor_id;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } front_out_type;

   // (a + b) mod 255 for a < 255
   function automatic logic [BYTE_W-1:0] mod255_add(logic [BYTE_W-1:0] a,
                                                     logic [BYTE_W-1:0] b);
      logic [BYTE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 9'd255) begin
         s = s - 9'd255;
      end
      return s[BYTE_W-1:0];
   endfunction

endpackage

// File: hdl/sffd_ram.sv
module sffd_ram import sffd_pkg::*; #(
   parameter int WIDTH = BYTE_W,
   parameter int DEPTH = MAX_FRAME_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sffd_front.sv
module sffd_front import sffd_pkg::*; #(
   parameter int DEPTH = FRONT_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic              pop,
   output front_out_type     front_out
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [BYTE_W-1:0] fifo_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              push;
   logic              take;

   assign req_ready       = cnt_ff != CW'(DEPTH);
   assign push            = req_valid && req_ready;
   assign take            = pop && front_out.valid;
   assign front_out.valid = cnt_ff != '0;
   assign front_out.data  = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      cnt_in = cnt_ff + CW'(push) - CW'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= req_rx_byte;
      end
   end

endmodule

// File: hdl/sffd_back.sv
module sffd_back import sffd_pkg::*; #(
   parameter int MAX_FRAME    = MAX_FRAME_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  front_out_type       front_out,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_frame_byte,
   output logic [POS_W-1:0]    rsp_byte_position,
   output logic [KIND_W-1:0]   rsp_message_kind,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last,
   output logic [TOTAL_W-1:0]  rsp_bad_checksum_total,
   output logic [TOTAL_W-1:0]  rsp_unknown_id_total
);

   localparam int PTR_W  = $clog2(MAX_FRAME);
   localparam int CNT_W  = $clog2(MAX_FRAME + 1);
   localparam int WIDE_W = BYTE_W + 1;

   // ring buffer offset add, wraps at MAX_FRAME
   function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] base,
                                                  logic [BYTE_W-1:0] step);
      logic [WIDE_W-1:0] s;
      s = WIDE_W'(base) + WIDE_W'(step);
      if (s >= WIDE_W'(MAX_FRAME)) begin
         s = s - WIDE_W'(MAX_FRAME);
      end
      return s[PTR_W-1:0];
   endfunction

   phase_type           state_ff, state_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                done_ff, done_in;
   logic [TOTAL_W-1:0]  bad_cnt_ff, bad_cnt_in;
   logic [TOTAL_W-1:0]  unk_cnt_ff, unk_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [BYTE_W-1:0]   len_ff, len_in;
   logic [BYTE_W-1:0]   pos_ff, pos_in;
   logic [BYTE_W-1:0]   low_ff, low_in;
   logic [BYTE_W-1:0]   high_ff, high_in;
   logic [BYTE_W-1:0]   id_ff, id_in;
   logic [BYTE_W-1:0]   trail_lo_ff, trail_lo_in;
   logic [BYTE_W-1:0]   trail_hi_ff, trail_hi_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [BYTE_W-1:0]   rsp_frame_byte_ff, rsp_frame_byte_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [TOTAL_W-1:0]  rsp_bad_ff, rsp_bad_in;
   logic [TOTAL_W-1:0]  rsp_unk_ff, rsp_unk_in;

   logic                mem_wr_en;
   logic [PTR_W-1:0]    mem_wr_addr;
   logic                mem_rd_en;
   logic [PTR_W-1:0]    mem_rd_addr;
   logic [BYTE_W-1:0]   mem_rd_data;

   logic                slot_free;
   logic                is_sync;
   logic                short_hdr;
   logic                len_bad;
   logic                short_frame;
   logic                at_last;
   logic                in_sum;
   logic                trailer_ok;
   logic                id_known;
   logic [KIND_W-1:0]   id_kind;
   logic [BYTE_W-1:0]   low_sum;
   logic [BYTE_W-1:0]   high_sum;

   sffd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_FRAME)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (front_out.data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign is_sync     = mem_rd_data == cfg.sync_byte;
   assign short_hdr   = count_ff < CNT_W'(HEADER_BYTES);
   assign len_bad     = (mem_rd_data >= BYTE_W'(MAX_FRAME)) ||
                        (mem_rd_data < BYTE_W'(HEADER_BYTES));
   assign short_frame = WIDE_W'(count_ff) < WIDE_W'(mem_rd_data);
   assign at_last     = pos_ff == len_ff - 8'd1;
   assign in_sum      = (WIDE_W'(pos_ff) + 9'd2) < WIDE_W'(len_ff);
   assign trailer_ok  = {trail_hi_ff, trail_lo_ff} == {high_ff, low_ff};
   assign low_sum     = mod255_add(low_ff, mem_rd_data);
   assign high_sum    = mod255_add(high_ff, low_sum);

   always_comb begin
      id_known = 1'b1;
      id_kind  = KIND_BATTERY;
      if (id_ff == cfg.battery_id) begin
         id_kind = KIND_BATTERY;
      end else if (id_ff == cfg.analog_id) begin
         id_kind = KIND_ANALOG;
      end else if (id_ff == cfg.thermistor_id) begin
         id_kind = KIND_THERMISTOR;
      end else begin
         id_known = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PH_IDLE: begin
            if (front_out.valid) begin
               state_in = PH_SCAN;
            end
         end
         PH_SCAN: begin
            state_in = (count_ff == '0) ? PH_IDLE : PH_HDR0;
         end
         PH_HDR0: begin
            if (!is_sync) begin
               state_in = PH_SCAN;
            end else if (short_hdr) begin
               state_in = PH_IDLE;
            end else begin
               state_in = PH_HDR2;
            end
         end
         PH_HDR2: begin
            if (len_bad) begin
               state_in = PH_SCAN;
            end else if (short_frame || done_ff) begin
               state_in = PH_IDLE;
            end else begin
               state_in = PH_SUM;
            end
         end
         PH_SUM: begin
            if (at_last) begin
               state_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            state_in = (trailer_ok && id_known) ? PH_EMIT_RD : PH_STATUS;
         end
         PH_STATUS: begin
            if (slot_free) begin
               state_in = PH_SCAN;
            end
         end
         PH_EMIT_RD: begin
            state_in = PH_EMIT_WR;
         end
         PH_EMIT_WR: begin
            if (slot_free) begin
               state_in = at_last ? PH_SCAN : PH_EMIT_RD;
            end
         end
         default: begin
            state_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ring_add(head_ff, BYTE_W'(count_ff));
      mem_rd_en    = 1'b0;
      mem_rd_addr  = head_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      bad_cnt_in   = bad_cnt_ff;
      unk_cnt_in   = unk_cnt_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      id_in        = id_ff;
      trail_lo_in  = trail_lo_ff;
      trail_hi_in  = trail_hi_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_frame_byte_in = rsp_frame_byte_ff;
      rsp_pos_in        = rsp_pos_ff;
      rsp_kind_in       = rsp_kind_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_bad_in        = rsp_bad_ff;
      rsp_unk_in        = rsp_unk_ff;

      case (state_ff)
         PH_IDLE: begin
            if (front_out.valid) begin
               pop     = 1'b1;
               done_in = 1'b0;
               if (count_ff != CNT_W'(MAX_FRAME)) begin
                  mem_wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
         end
         PH_SCAN: begin
            mem_rd_en = count_ff != '0;
         end
         PH_HDR0: begin
            if (!is_sync) begin
               head_in  = ring_add(head_ff, 8'd1);
               count_in = count_ff - CNT_W'(1);
            end else if (!short_hdr) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ring_add(head_ff, 8'd2);
            end
         end
         PH_HDR2: begin
            if (len_bad) begin
               head_in  = ring_add(head_ff, 8'd1);
               count_in = count_ff - CNT_W'(1);
            end else if (!(short_frame || done_ff)) begin
               len_in    = mem_rd_data;
               pos_in    = '0;
               low_in    = '0;
               high_in   = '0;
               mem_rd_en = 1'b1;
            end
         end
         PH_SUM: begin
            if (in_sum) begin
               low_in  = low_sum;
               high_in = high_sum;
            end
            if (pos_ff == 8'd1) begin
               id_in = mem_rd_data;
            end
            if (pos_ff == len_ff - 8'd2) begin
               trail_lo_in = mem_rd_data;
            end
            if (at_last) begin
               trail_hi_in = mem_rd_data;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ring_add(head_ff, pos_ff + 8'd1);
               pos_in      = pos_ff + 8'd1;
            end
         end
         PH_CHECK: begin
            if (!trailer_ok) begin
               bad_cnt_in = bad_cnt_ff + TOTAL_W'(1);
               status_in  = STATUS_BAD_SUM;
            end else if (!id_known) begin
               unk_cnt_in = unk_cnt_ff + TOTAL_W'(1);
               status_in  = STATUS_UNKNOWN_ID;
            end else begin
               kind_in = id_kind;
               pos_in  = '0;
            end
         end
         PH_STATUS: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_frame_byte_in = '0;
               rsp_pos_in        = '0;
               rsp_kind_in       = KIND_BATTERY;
               rsp_status_in     = status_ff;
               rsp_last_in       = 1'b1;
               rsp_bad_in        = bad_cnt_ff;
               rsp_unk_in        = unk_cnt_ff;
               head_in           = ring_add(head_ff, len_ff);
               count_in          = count_ff - CNT_W'(len_ff);
               done_in           = 1'b1;
            end
         end
         PH_EMIT_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ring_add(head_ff, pos_ff);
         end
         PH_EMIT_WR: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_frame_byte_in = mem_rd_data;
               rsp_pos_in        = pos_ff[POS_W-1:0];
               rsp_kind_in       = kind_ff;
               rsp_status_in     = STATUS_FRAME;
               rsp_last_in       = at_last;
               rsp_bad_in        = bad_cnt_ff;
               rsp_unk_in        = unk_cnt_ff;
               if (at_last) begin
                  head_in  = ring_add(head_ff, len_ff);
                  count_in = count_ff - CNT_W'(len_ff);
                  done_in  = 1'b1;
               end else begin
                  pos_in = pos_ff + 8'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PH_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         bad_cnt_ff   <= '0;
         unk_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         bad_cnt_ff   <= bad_cnt_in;
         unk_cnt_ff   <= unk_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff            <= len_in;
      pos_ff            <= pos_in;
      low_ff            <= low_in;
      high_ff           <= high_in;
      id_ff             <= id_in;
      trail_lo_ff       <= trail_lo_in;
      trail_hi_ff       <= trail_hi_in;
      kind_ff           <= kind_in;
      status_ff         <= status_in;
      rsp_frame_byte_ff <= rsp_frame_byte_in;
      rsp_pos_ff        <= rsp_pos_in;
      rsp_kind_ff       <= rsp_kind_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_last_ff       <= rsp_last_in;
      rsp_bad_ff        <= rsp_bad_in;
      rsp_unk_ff        <= rsp_unk_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_frame_byte         = rsp_frame_byte_ff;
   assign rsp_byte_position      = rsp_pos_ff;
   assign rsp_message_kind       = rsp_kind_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_last               = rsp_last_ff;
   assign rsp_bad_checksum_total = rsp_bad_ff;
   assign rsp_unknown_id_total   = rsp_unk_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAME))
      else $error("frame store count overflow");

   a_sum_whole_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == PH_SUM |-> WIDE_W'(count_ff) >= WIDE_W'(len_ff))
      else $error("checksum started on partial frame");

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_FRAME |->
         rsp_last_ff && rsp_frame_byte_ff == '0 && rsp_pos_ff == '0)
      else $error("malformed status result");

   a_bad_cnt_src: assert property (@(posedge clock) disable iff (reset)
      !$stable(bad_cnt_ff) |-> $past(state_ff) == PH_CHECK)
      else $error("bad checksum counter moved outside check");

endmodule

// File: hdl/sync_frame_fletcher_deframer.sv
// Sync/length framed byte deframer with Fletcher-16 check. Bytes enter on the
// req_ channel into a small input queue; a parse engine appends each byte to a
// 64-entry ring store and rescans it for sync and length. A complete frame
// is summed (Fletcher-16 mod 255, sum2 high, trailer little-endian) and then
// either drained byte by byte on rsp_ with its kind, or reported as a single
// status transfer with last set. At most one frame completes per input byte.
// Timing is set by the single read port of the ring store. Each byte is first
// taken into the store, then a rescan drops non-sync bytes one by one, drops a
// sync byte with a bad length, and stops on an empty store, a short header or
// a partial frame. A complete frame is checksummed and then drained byte by
// byte (or sent as its status transfer) before the rescan goes on; any rsp_
// stall holds the drain or the status transfer.
// csr_ writes (0 sync, 1 battery id, 2 analog id, 3 thermistor id) take effect
// at once and belong only in times when the block is idle.
module sync_frame_fletcher_deframer import sffd_pkg::*; #(
   parameter int MAX_FRAME    = MAX_FRAME_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int FRONT_DEPTH  = FRONT_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_frame_byte,
   output logic [POS_W-1:0]     rsp_byte_position,
   output logic [KIND_W-1:0]    rsp_message_kind,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_last,
   output logic [TOTAL_W-1:0]   rsp_bad_checksum_total,
   output logic [TOTAL_W-1:0]   rsp_unknown_id_total,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wr_data
);

   cfg_type       cfg_ff, cfg_in;
   front_out_type front_out;
   logic          pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SYNC:       cfg_in.sync_byte     = csr_wr_data;
            CSR_BATTERY_ID: cfg_in.battery_id    = csr_wr_data;
            CSR_ANALOG_ID:  cfg_in.analog_id     = csr_wr_data;
            CSR_THERM_ID:   cfg_in.thermistor_id = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte     <= SYNC_RESET;
         cfg_ff.battery_id    <= BATTERY_ID_RESET;
         cfg_ff.analog_id     <= ANALOG_ID_RESET;
         cfg_ff.thermistor_id <= THERM_ID_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sffd_front #(
      .DEPTH (FRONT_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .pop         (pop),
      .front_out   (front_out)
   );

   sffd_back #(
      .MAX_FRAME    (MAX_FRAME),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg_ff),
      .front_out              (front_out),
      .pop                    (pop),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_frame_byte         (rsp_frame_byte),
      .rsp_byte_position      (rsp_byte_position),
      .rsp_message_kind       (rsp_message_kind),
      .rsp_status             (rsp_status),
      .rsp_last               (rsp_last),
      .rsp_bad_checksum_total (rsp_bad_checksum_total),
      .rsp_unknown_id_total   (rsp_unknown_id_total)
   );

endmodule

// File: verif/sffd_checker.sv
`timescale 1ns / 100ps

module sffd_checker import sffd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [BYTE_W-1:0]    rsp_frame_byte,
   input  logic [POS_W-1:0]     rsp_byte_position,
   input  logic [KIND_W-1:0]    rsp_message_kind,
   input  logic [STATUS_W-1:0]  rsp_status,
   input  logic                 rsp_last,
   input  logic [TOTAL_W-1:0]   rsp_bad_checksum_total,
   input  logic [TOTAL_W-1:0]   rsp_unknown_id_total,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wr_data,
   output int                   fail_count,
   output int                   awaited,
   output int                   held,
   output int                   checked
);

   typedef struct {
      logic [BYTE_W-1:0]   data;
      logic [POS_W-1:0]    pos;
      logic [KIND_W-1:0]   kind;
      logic [STATUS_W-1:0] status;
      logic                last;
      logic [TOTAL_W-1:0]  bad_total;
      logic [TOTAL_W-1:0]  unknown_total;
   } frame_out_type;

   cfg_type           cfg;
   logic [BYTE_W-1:0] held_bytes[$];
   frame_out_type     awaited_frame_out[$];
   logic [TOTAL_W-1:0] bad_sum_count;
   logic [TOTAL_W-1:0] unknown_id_count;

   initial begin
      fail_count = 0;
      awaited    = 0;
      held       = 0;
      checked    = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic queue_result(input logic [BYTE_W-1:0] data, input int pos,
                               input logic [KIND_W-1:0] kind,
                               input logic [STATUS_W-1:0] status, input logic last);
      frame_out_type r;
      r.data          = data;
      r.pos           = pos[POS_W-1:0];
      r.kind          = kind;
      r.status        = status;
      r.last          = last;
      r.bad_total     = bad_sum_count;
      r.unknown_total = unknown_id_count;
      awaited_frame_out.push_back(r);
   endtask

   // whole frame held at the front of the store
   task automatic close_frame(input int len);
      int                lo;
      int                hi;
      int                i;
      logic [BYTE_W-1:0] id;
      logic [KIND_W-1:0] kind;
      bit                known;
      lo = 0;
      hi = 0;
      for (i = 0; i + 2 < len; i++) begin
         lo = (lo + int'(held_bytes[i])) % 255;
         hi = (hi + lo) % 255;
      end
      if ({held_bytes[len-1], held_bytes[len-2]} != {hi[7:0], lo[7:0]}) begin
         bad_sum_count++;
         queue_result('0, 0, KIND_BATTERY, STATUS_BAD_SUM, 1'b1);
      end else begin
         id    = held_bytes[1];
         known = 1'b1;
         kind  = KIND_BATTERY;
         if (id == cfg.battery_id) kind = KIND_BATTERY;
         else if (id == cfg.analog_id) kind = KIND_ANALOG;
         else if (id == cfg.thermistor_id) kind = KIND_THERMISTOR;
         else known = 1'b0;
         if (!known) begin
            unknown_id_count++;
            queue_result('0, 0, KIND_BATTERY, STATUS_UNKNOWN_ID, 1'b1);
         end else begin
            for (i = 0; i < len; i++)
               queue_result(held_bytes[i], i, kind, STATUS_FRAME, i + 1 == len);
         end
      end
      repeat (len) void'(held_bytes.pop_front());
   endtask

   task automatic deframe_byte(input logic [BYTE_W-1:0] value);
      int len;
      bit closed;
      closed = 1'b0;
      if (held_bytes.size() < MAX_FRAME_DEF) held_bytes.push_back(value);
      while (held_bytes.size() != 0) begin
         if (held_bytes[0] != cfg.sync_byte) begin
            void'(held_bytes.pop_front());
            continue;
         end
         if (held_bytes.size() < HEADER_BYTES_DEF) break;
         len = int'(held_bytes[2]);
         if (len >= MAX_FRAME_DEF || len < HEADER_BYTES_DEF) begin
            void'(held_bytes.pop_front());
            continue;
         end
         if (held_bytes.size() < len || closed) break;
         close_frame(len);
         closed = 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch
      frame_out_type want;
      if (reset) begin
         cfg.sync_byte     = SYNC_RESET;
         cfg.battery_id    = BATTERY_ID_RESET;
         cfg.analog_id     = ANALOG_ID_RESET;
         cfg.thermistor_id = THERM_ID_RESET;
         held_bytes.delete();
         awaited_frame_out.delete();
         bad_sum_count    = '0;
         unknown_id_count = '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SYNC:       cfg.sync_byte     = csr_wr_data;
               CSR_BATTERY_ID: cfg.battery_id    = csr_wr_data;
               CSR_ANALOG_ID:  cfg.analog_id     = csr_wr_data;
               CSR_THERM_ID:   cfg.thermistor_id = csr_wr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) deframe_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            if (awaited_frame_out.size() == 0) begin
               report_mismatch("transfer with nothing expected, frame_byte",
                               int'(rsp_frame_byte), 0);
            end else begin
               want = awaited_frame_out.pop_front();
               checked++;
               if (rsp_frame_byte != want.data)
                  report_mismatch("frame_byte", int'(rsp_frame_byte), int'(want.data));
               if (rsp_byte_position != want.pos)
                  report_mismatch("byte_position", int'(rsp_byte_position),
                                  int'(want.pos));
               if (rsp_message_kind != want.kind)
                  report_mismatch("message_kind", int'(rsp_message_kind),
                                  int'(want.kind));
               if (rsp_status != want.status)
                  report_mismatch("status", int'(rsp_status), int'(want.status));
               if (rsp_last != want.last)
                  report_mismatch("last", int'(rsp_last), int'(want.last));
               if (rsp_bad_checksum_total != want.bad_total)
                  report_mismatch("bad_checksum_total", int'(rsp_bad_checksum_total),
                                  int'(want.bad_total));
               if (rsp_unknown_id_total != want.unknown_total)
                  report_mismatch("unknown_id_total", int'(rsp_unknown_id_total),
                                  int'(want.unknown_total));
            end
         end
      end
      awaited <= awaited_frame_out.size();
      held    <= held_bytes.size();
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import sffd_pkg::*;

   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 400;

   typedef enum int {FRAME_CLEAN, FRAME_CORRUPT, FRAME_TRUNCATED} frame_flaw_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BYTE_W-1:0]    rsp_frame_byte;
   logic [POS_W-1:0]     rsp_byte_position;
   logic [KIND_W-1:0]    rsp_message_kind;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_last;
   logic [TOTAL_W-1:0]   rsp_bad_checksum_total;
   logic [TOTAL_W-1:0]   rsp_unknown_id_total;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]    csr_wr_data = '0;

   int fail_count;
   int awaited;
   int held;
   int checked;

   logic [BYTE_W-1:0] cur_sync = SYNC_RESET;
   logic [BYTE_W-1:0] cur_bat  = BATTERY_ID_RESET;
   logic [BYTE_W-1:0] cur_ana  = ANALOG_ID_RESET;
   logic [BYTE_W-1:0] cur_ther = THERM_ID_RESET;

   int bytes_sent  = 0;
   int stall_count = 0;
   int rsp_hold    = 0;
   int calm_left   = 0;
   bit calm        = 1'b0;

   sync_frame_fletcher_deframer u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_rx_byte            (req_rx_byte),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_frame_byte         (rsp_frame_byte),
      .rsp_byte_position      (rsp_byte_position),
      .rsp_message_kind       (rsp_message_kind),
      .rsp_status             (rsp_status),
      .rsp_last               (rsp_last),
      .rsp_bad_checksum_total (rsp_bad_checksum_total),
      .rsp_unknown_id_total   (rsp_unknown_id_total),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wr_data            (csr_wr_data)
   );

   sffd_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_rx_byte            (req_rx_byte),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_frame_byte         (rsp_frame_byte),
      .rsp_byte_position      (rsp_byte_position),
      .rsp_message_kind       (rsp_message_kind),
      .rsp_status             (rsp_status),
      .rsp_last               (rsp_last),
      .rsp_bad_checksum_total (rsp_bad_checksum_total),
      .rsp_unknown_id_total   (rsp_unknown_id_total),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wr_data            (csr_wr_data),
      .fail_count             (fail_count),
      .awaited                (awaited),
      .held                   (held),
      .checked                (checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stretches with no idling on either side
   always @(posedge clock) begin
      if (calm_left == 0) begin
         calm      = ($urandom_range(0, 3) == 0);
         calm_left = $urandom_range(50, 300);
      end else begin
         calm_left--;
      end
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("no transfer for %0d cycles", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [BYTE_W-1:0] id, input int len,
                             input frame_flaw_type flaw);
      logic [BYTE_W-1:0] fr[MAX_FRAME_DEF];
      int n;
      int lo;
      int hi;
      int k;
      n = (len >= HEADER_BYTES_DEF && len < MAX_FRAME_DEF) ? len : HEADER_BYTES_DEF;
      fr[0] = cur_sync;
      fr[1] = id;
      fr[2] = len[7:0];
      for (k = 3; k < n; k++) fr[k] = BYTE_W'($urandom_range(0, 255));
      if (n >= 5) begin
         lo = 0;
         hi = 0;
         for (k = 0; k < n - 2; k++) begin
            lo = (lo + fr[k]) % 255;
            hi = (hi + lo) % 255;
         end
         fr[n-2] = lo[7:0];
         fr[n-1] = hi[7:0];
      end
      if (flaw == FRAME_CORRUPT && n > 3) begin
         k     = $urandom_range(3, n - 1);
         fr[k] = fr[k] ^ (8'd1 << $urandom_range(0, 7));
      end
      if (flaw == FRAME_TRUNCATED && n > 3) n = $urandom_range(3, n - 1);
      for (k = 0; k < n; k++) send_byte(fr[k]);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (awaited != 0) @(negedge clock);
   endtask

   // empty the frame store with non-sync filler, then let the block go quiet
   task automatic settle();
      hold_until_drained();
      if (held != 0) begin
         while (held != 0) send_byte(cur_sync + 8'd1);
         hold_until_drained();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_config(input logic [BYTE_W-1:0] s, b, a, t);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_SYNC;
      csr_wr_data <= s;
      @(negedge clock);
      csr_index   <= CSR_BATTERY_ID;
      csr_wr_data <= b;
      @(negedge clock);
      csr_index   <= CSR_ANALOG_ID;
      csr_wr_data <= a;
      @(negedge clock);
      csr_index   <= CSR_THERM_ID;
      csr_wr_data <= t;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      cur_sync = s;
      cur_bat  = b;
      cur_ana  = a;
      cur_ther = t;
   endtask

   function automatic logic [BYTE_W-1:0] pick_known_id();
      case ($urandom_range(0, 2))
         0:       return cur_bat;
         1:       return cur_ana;
         default: return cur_ther;
      endcase
   endfunction

   task automatic random_phase(input int target);
      int                start;
      int                r;
      int                len;
      logic [BYTE_W-1:0] id;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         if ($urandom_range(0, 9) == 0) hold_until_drained();
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 9) == 0)
            len = ($urandom_range(0, 1) == 0) ? 63 : $urandom_range(13, 62);
         else
            len = $urandom_range(5, 12);
         if (r < 58) begin
            send_frame(pick_known_id(), len, FRAME_CLEAN);
         end else if (r < 66) begin
            do id = BYTE_W'($urandom_range(0, 255));
            while (id == cur_bat || id == cur_ana || id == cur_ther);
            send_frame(id, len, FRAME_CLEAN);
         end else if (r < 76) begin
            send_frame(pick_known_id(), len, FRAME_CORRUPT);
         end else if (r < 82) begin
            send_frame(pick_known_id(), len, FRAME_TRUNCATED);
         end else if (r < 88) begin
            len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2) : $urandom_range(64, 255);
            send_frame(pick_known_id(), len, FRAME_CLEAN);
         end else if (r < 92) begin
            send_frame(pick_known_id(), $urandom_range(3, 4), FRAME_CLEAN);
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      random_phase(25);

      settle();
      write_config(8'hA5, 8'h11, 8'h22, 8'h33);
      send_frame(8'h11, 2, FRAME_CLEAN);     // length under header size
      send_frame(8'h22, 64, FRAME_CLEAN);    // length at store size
      send_frame(8'h33, 3, FRAME_CLEAN);     // header-only frame
      send_frame(8'h11, 5, FRAME_CLEAN);
      send_frame(8'h22, 5, FRAME_CORRUPT);
      send_frame(8'h33, 5, FRAME_CLEAN);
      send_frame(8'hFF, 5, FRAME_CLEAN);     // unknown id
      random_phase(40);

      settle();
      write_config(8'hFF, 8'h00, 8'hFF, 8'h80);
      random_phase(35);

      settle();
      write_config(8'h5A, 8'h44, 8'h44, 8'h44);  // all ids equal
      random_phase(35);

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d bytes under four register settings, sync 0x00/0xA5/0xFF/0x5A,",
               bytes_sent);
      $display("with noise, bad lengths, bad sums and unknown ids; %0d transfers checked",
               checked);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
